// File: rtl/core/pidc_pkg.sv
// Shared constants, codes and the microcode program of the PID step core.
package pidc_pkg;

  // Default datapath format: signed Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of one multiplier chunk (operand bits taken per cycle)
  localparam int MUL_CHUNK = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_SETTLE_BAND   = 3'd3,
    REG_DRIVE_FLOOR   = 3'd4,
    REG_DRIVE_CEILING = 3'd5,
    REG_TARGET        = 3'd6
  } cfg_reg_t;

  // Sequencer step addresses
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_IDLE     = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_ERR      = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_CHECK    = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_MUL_I1   = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_WAIT_I1  = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_MUL_I2   = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_WAIT_I2  = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_INT_SUM  = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_INT_CLMP = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_WAIT_P   = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_P_SUM    = STEP_W'(10);
  localparam logic [STEP_W-1:0] ST_WAIT_DIV = STEP_W'(11);
  localparam logic [STEP_W-1:0] ST_MUL_D    = STEP_W'(12);
  localparam logic [STEP_W-1:0] ST_WAIT_D   = STEP_W'(13);
  localparam logic [STEP_W-1:0] ST_D_SUB    = STEP_W'(14);
  localparam logic [STEP_W-1:0] ST_DRIVE    = STEP_W'(15);
  localparam logic [STEP_W-1:0] ST_SETTLE   = STEP_W'(16);

  // Sequencing of a step
  typedef enum logic [2:0] {
    J_NEXT,        // advance
    J_STAY_IN,     // hold until an input transfer
    J_STAY_MUL,    // hold while the multiplier is busy
    J_STAY_DIV,    // hold while the divider is busy
    J_IF_SETTLED,  // jump to target when the error lies in the settle band
    J_OUT          // hold until the result register is free, then jump to target
  } jmp_t;

  // Multiplier operand selects
  typedef enum logic [1:0] {
    MA_GAIN_I,
    MA_GAIN_P,
    MA_GAIN_D,
    MA_RESULT
  } mula_t;

  typedef enum logic [1:0] {
    MB_ERR,
    MB_ELAPSED,
    MB_RATE
  } mulb_t;

  // Datapath operations
  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,       // capture the input item
    A_ERR,        // error and measurement difference
    A_CHECK,      // saturate error, decide whether the rate is used
    A_INT_SUM,    // integral plus increment
    A_INT_CLAMP,  // saturate and clamp the new integral
    A_P_SUM,      // proportional term plus integral
    A_D_SUB,      // subtract derivative term
    A_DRIVE,      // deliver drive, commit state
    A_SETTLE      // deliver settled result
  } alu_t;

  typedef struct packed {
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              mul_go;
    mula_t             mul_a;
    mulb_t             mul_b;
    logic              div_go;
    alu_t              alu;
  } ucw_t;

  // Control store
  function automatic ucw_t ucode(input logic [STEP_W-1:0] s);
    ucw_t w;
    w.jmp    = J_NEXT;
    w.target = ST_IDLE;
    w.mul_go = 1'b0;
    w.mul_a  = MA_GAIN_I;
    w.mul_b  = MB_ERR;
    w.div_go = 1'b0;
    w.alu    = A_NONE;
    case (s)
      ST_IDLE: begin
        w.jmp = J_STAY_IN;
        w.alu = A_LOAD;
      end
      ST_ERR: begin
        w.alu = A_ERR;
      end
      ST_CHECK: begin
        w.jmp    = J_IF_SETTLED;
        w.target = ST_SETTLE;
        w.alu    = A_CHECK;
      end
      ST_MUL_I1: begin
        w.mul_go = 1'b1;
        w.mul_a  = MA_GAIN_I;
        w.mul_b  = MB_ERR;
        w.div_go = 1'b1;
      end
      ST_WAIT_I1: begin
        w.jmp = J_STAY_MUL;
      end
      ST_MUL_I2: begin
        w.mul_go = 1'b1;
        w.mul_a  = MA_RESULT;
        w.mul_b  = MB_ELAPSED;
      end
      ST_WAIT_I2: begin
        w.jmp = J_STAY_MUL;
      end
      ST_INT_SUM: begin
        w.alu    = A_INT_SUM;
        w.mul_go = 1'b1;
        w.mul_a  = MA_GAIN_P;
        w.mul_b  = MB_ERR;
      end
      ST_INT_CLMP: begin
        w.alu = A_INT_CLAMP;
      end
      ST_WAIT_P: begin
        w.jmp = J_STAY_MUL;
      end
      ST_P_SUM: begin
        w.alu = A_P_SUM;
      end
      ST_WAIT_DIV: begin
        w.jmp = J_STAY_DIV;
      end
      ST_MUL_D: begin
        w.mul_go = 1'b1;
        w.mul_a  = MA_GAIN_D;
        w.mul_b  = MB_RATE;
      end
      ST_WAIT_D: begin
        w.jmp = J_STAY_MUL;
      end
      ST_D_SUB: begin
        w.alu = A_D_SUB;
      end
      ST_DRIVE: begin
        w.jmp    = J_OUT;
        w.target = ST_IDLE;
        w.alu    = A_DRIVE;
      end
      ST_SETTLE: begin
        w.jmp    = J_OUT;
        w.target = ST_IDLE;
        w.alu    = A_SETTLE;
      end
      default: begin
        w.jmp    = J_OUT;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/pidc_mul.sv
// Chunked fixed-point multiplier with rounding and saturation.
module pidc_mul #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         busy,
  output logic signed [DATA_WIDTH-1:0] res
);

  localparam int W   = DATA_WIDTH;
  localparam int CH  = pidc_pkg::MUL_CHUNK;
  localparam int NCH = (W + CH - 1) / CH;
  localparam int YW  = NCH * CH;
  localparam int PW  = W + YW;
  localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic [PW-1:0] HALF    = (PW'(1) << FRAC_BITS) >> 1;
  localparam logic [PW-1:0] POS_LIM = (PW'(1) << (W - 1)) - PW'(1);
  localparam logic [PW-1:0] NEG_LIM = PW'(1) << (W - 1);

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_ROUND,
    M_SAT
  } mstate_t;

  mstate_t           state_r;
  logic [KW-1:0]     cnt_r;
  logic [W-1:0]      xm_r;
  logic [YW-1:0]     ysh_r;
  logic [W-1:0]      hi_r;
  logic [YW-1:0]     lo_r;
  logic              neg_r;
  logic [PW-1:0]     rs_r;
  logic [W-1:0]      res_r;

  logic [W-1:0]      a_mag;
  logic [W-1:0]      b_mag;
  logic [W+CH-1:0]   part;
  logic [YW+CH-1:0]  lo_cat;
  logic [W-1:0]      rs_neg;

  // Operand magnitudes
  assign a_mag = a[W-1] ? ($unsigned('0) - $unsigned(a)) : $unsigned(a);
  assign b_mag = b[W-1] ? ($unsigned('0) - $unsigned(b)) : $unsigned(b);

  // One chunk of the multiplier operand per cycle
  assign part   = (W + CH)'(hi_r) + (W + CH)'(xm_r) * (W + CH)'(ysh_r[CH-1:0]);
  assign lo_cat = {part[CH-1:0], lo_r};
  assign rs_neg = '0 - rs_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        M_IDLE: begin
          if (go) begin
            xm_r    <= a_mag;
            ysh_r   <= YW'(b_mag);
            neg_r   <= a[W-1] ^ b[W-1];
            hi_r    <= '0;
            lo_r    <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          hi_r  <= part[W+CH-1:CH];
          lo_r  <= lo_cat[YW+CH-1:CH];
          ysh_r <= ysh_r >> CH;
          cnt_r <= cnt_r + KW'(1);
          if (cnt_r == KW'(NCH - 1)) begin
            state_r <= M_ROUND;
          end
        end
        M_ROUND: begin
          // round half away from zero on the magnitude, drop fraction bits
          rs_r    <= ({hi_r, lo_r} + HALF) >> FRAC_BITS;
          state_r <= M_SAT;
        end
        M_SAT: begin
          if (neg_r) begin
            res_r <= (rs_r > NEG_LIM) ? {1'b1, {(W-1){1'b0}}} : rs_neg;
          end else begin
            res_r <= (rs_r > POS_LIM) ? {1'b0, {(W-1){1'b1}}} : rs_r[W-1:0];
          end
          state_r <= M_IDLE;
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != M_IDLE);
  assign res  = $signed(res_r);

endmodule

// File: rtl/core/pidc_div.sv
// Radix-2 restoring divider for the rate term, with rounding and saturation.
module pidc_div #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic signed [DATA_WIDTH:0]   num,
  input  logic        [DATA_WIDTH-2:0] den,
  output logic                         busy,
  output logic signed [DATA_WIDTH-1:0] quo
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = W + FRAC_BITS;
  localparam int QW = NW + 1;
  localparam int CW = $clog2(NW);

  localparam logic [QW-1:0] POS_LIM = (QW'(1) << (W - 1)) - QW'(1);
  localparam logic [QW-1:0] NEG_LIM = QW'(1) << (W - 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_ROUND,
    D_SAT
  } dstate_t;

  dstate_t         state_r;
  logic [CW-1:0]   cnt_r;
  logic [NW-1:0]   nq_r;
  logic [W-2:0]    rem_r;
  logic [W-2:0]    den_r;
  logic            neg_r;
  logic [QW-1:0]   q_r;
  logic [W-1:0]    quo_r;

  logic [W:0]      num_abs;
  logic [W-1:0]    trial;
  logic [W-1:0]    trial_sub;
  logic            take;
  logic            round_up;
  logic [W-1:0]    q_neg;

  // Dividend magnitude
  assign num_abs = num[W] ? ($unsigned('0) - $unsigned(num)) : $unsigned(num);

  // Shift in one dividend bit, try the subtraction
  assign trial     = {rem_r, nq_r[NW-1]};
  assign take      = (trial >= {1'b0, den_r});
  assign trial_sub = trial - {1'b0, den_r};
  assign round_up  = ({rem_r, 1'b0} >= {1'b0, den_r});
  assign q_neg     = '0 - q_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (go) begin
            nq_r    <= NW'(num_abs[W-1:0]) << FRAC_BITS;
            rem_r   <= '0;
            den_r   <= den;
            neg_r   <= num[W];
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= take ? trial_sub[W-2:0] : trial[W-2:0];
          nq_r  <= {nq_r[NW-2:0], take};
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(NW - 1)) begin
            state_r <= D_ROUND;
          end
        end
        D_ROUND: begin
          // round half away from zero on the magnitude
          q_r     <= QW'(nq_r) + QW'(round_up);
          state_r <= D_SAT;
        end
        D_SAT: begin
          if (neg_r) begin
            quo_r <= (q_r > NEG_LIM) ? {1'b1, {(W-1){1'b0}}} : q_neg;
          end else begin
            quo_r <= (q_r > POS_LIM) ? {1'b0, {(W-1){1'b1}}} : q_r[W-1:0];
          end
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != D_IDLE);
  assign quo  = $signed(quo_r);

endmodule

// File: rtl/core/pid_controller_step_core.sv
// Top level of the PID step core: microcoded sequencer, datapath and registers.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_measurement, in_elapsed
//  out      output     out_valid/out_stall  out_drive, out_settled
//  cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One item at a time. A settled item runs the error and check steps and
// then the settle step, which loads the result. Otherwise each of the four
// multiplies takes its operand in 16-bit chunks (NCH chunks, 2 at Q16.16),
// and the rate divider, started alongside the first multiply when the rate
// term is used, is waited for before the derivative multiply. The rate term
// is zero on the first item or with zero elapsed time; the divider result
// saturates to the signed Q16.16 range at the default widths.
// Reset is synchronous and stalls the input; the block takes an item in the
// first idle cycle after it.
// A stalled result holds in the output register while the next item is
// computed; that item then waits at its last step.
module pid_controller_step_core #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [DATA_WIDTH-1:0]       in_measurement,
  input  logic        [DATA_WIDTH-2:0]       in_elapsed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [DATA_WIDTH-1:0]       out_drive,
  output logic                               out_settled,
  input  logic                               cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_WIDTH-1:0]              cfg_wdata
);

  localparam int W = DATA_WIDTH;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  // Configuration registers
  logic signed [W-1:0] gain_p_r;
  logic signed [W-1:0] gain_i_r;
  logic signed [W-1:0] gain_d_r;
  logic        [W-2:0] settle_band_r;
  logic signed [W-1:0] drive_floor_r;
  logic signed [W-1:0] drive_ceiling_r;
  logic signed [W-1:0] target_r;

  // Loop state
  logic signed [W-1:0] integral_sum_r;
  logic signed [W-1:0] prior_meas_r;
  logic                primed_r;

  // Working registers
  logic [pidc_pkg::STEP_W-1:0] step_r;
  logic [pidc_pkg::STEP_W-1:0] step_nxt;
  logic signed [W-1:0]   meas_r;
  logic        [W-2:0]   dt_r;
  logic signed [W:0]     e_r;
  logic signed [W:0]     diff_r;
  logic signed [W-1:0]   err_r;
  logic signed [W+1:0]   acc_r;
  logic signed [W-1:0]   integ_r;
  logic                  use_rate_r;

  // Result register
  logic                  out_valid_r;
  logic signed [W-1:0]   out_drive_r;
  logic                  out_settled_r;

  pidc_pkg::ucw_t        ucw;
  logic                  step_fire;
  logic                  in_fire;
  logic                  slot_free;
  logic                  out_load;
  logic                  settled_c;
  logic signed [W:0]     band_x;
  logic signed [W:0]     e_plus_band;
  logic signed [W-1:0]   err_sat;
  logic                  mul_go;
  logic                  mul_busy;
  logic signed [W-1:0]   mul_a;
  logic signed [W-1:0]   mul_b;
  logic signed [W-1:0]   mul_res;
  logic                  div_go;
  logic                  div_busy;
  logic signed [W-1:0]   div_res;
  logic signed [W-1:0]   rate;

  function automatic logic signed [W-1:0] sat_acc(input logic signed [W+1:0] v);
    if (v > $signed({2'b00, SMAX})) begin
      return SMAX;
    end else if (v < $signed({2'b11, SMIN})) begin
      return SMIN;
    end
    return $signed(v[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] v,
                                                input logic signed [W-1:0] lo,
                                                input logic signed [W-1:0] hi);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r        <= '0;
      gain_i_r        <= '0;
      gain_d_r        <= '0;
      settle_band_r   <= '0;
      drive_floor_r   <= SMIN;
      drive_ceiling_r <= SMAX;
      target_r        <= '0;
    end else if (cfg_we) begin
      case (pidc_pkg::cfg_reg_t'(cfg_index))
        pidc_pkg::REG_GAIN_P:        gain_p_r        <= $signed(cfg_wdata);
        pidc_pkg::REG_GAIN_I:        gain_i_r        <= $signed(cfg_wdata);
        pidc_pkg::REG_GAIN_D:        gain_d_r        <= $signed(cfg_wdata);
        pidc_pkg::REG_SETTLE_BAND:   settle_band_r   <= cfg_wdata[W-2:0];
        pidc_pkg::REG_DRIVE_FLOOR:   drive_floor_r   <= $signed(cfg_wdata);
        pidc_pkg::REG_DRIVE_CEILING: drive_ceiling_r <= $signed(cfg_wdata);
        pidc_pkg::REG_TARGET:        target_r        <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Fetch the control word of the current step
  assign ucw       = pidc_pkg::ucode(step_r);
  assign in_stall  = !rst_n || (step_r != pidc_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Settle test on the exact error
  assign band_x      = $signed({2'b00, settle_band_r});
  assign e_plus_band = e_r + band_x;
  assign settled_c   = e_r[W] ? (!e_plus_band[W] && (e_plus_band != '0))
                              : (e_r < band_x);

  // Error saturated to the data width
  always_comb begin
    if (e_r[W] != e_r[W-1]) begin
      err_sat = e_r[W] ? SMIN : SMAX;
    end else begin
      err_sat = $signed(e_r[W-1:0]);
    end
  end

  // Step sequencing
  always_comb begin
    step_fire = 1'b1;
    step_nxt  = step_r + pidc_pkg::STEP_W'(1);
    case (ucw.jmp)
      pidc_pkg::J_NEXT: begin
        step_fire = 1'b1;
      end
      pidc_pkg::J_STAY_IN: begin
        step_fire = in_fire;
      end
      pidc_pkg::J_STAY_MUL: begin
        step_fire = !mul_busy;
      end
      pidc_pkg::J_STAY_DIV: begin
        step_fire = !div_busy;
      end
      pidc_pkg::J_IF_SETTLED: begin
        if (settled_c) begin
          step_nxt = ucw.target;
        end
      end
      pidc_pkg::J_OUT: begin
        step_fire = slot_free;
        step_nxt  = ucw.target;
      end
      default: begin
        step_nxt = pidc_pkg::ST_IDLE;
      end
    endcase
    if (!step_fire) begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pidc_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Multiplier operand selection
  assign rate = use_rate_r ? div_res : '0;

  always_comb begin
    case (ucw.mul_a)
      pidc_pkg::MA_GAIN_I: mul_a = gain_i_r;
      pidc_pkg::MA_GAIN_P: mul_a = gain_p_r;
      pidc_pkg::MA_GAIN_D: mul_a = gain_d_r;
      pidc_pkg::MA_RESULT: mul_a = mul_res;
      default:             mul_a = gain_i_r;
    endcase
    case (ucw.mul_b)
      pidc_pkg::MB_ERR:     mul_b = err_r;
      pidc_pkg::MB_ELAPSED: mul_b = $signed({1'b0, dt_r});
      pidc_pkg::MB_RATE:    mul_b = rate;
      default:              mul_b = err_r;
    endcase
  end

  assign mul_go = step_fire && ucw.mul_go;
  assign div_go = step_fire && ucw.div_go && use_rate_r;

  pidc_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .res   (mul_res)
  );

  pidc_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (diff_r),
    .den   (dt_r),
    .busy  (div_busy),
    .quo   (div_res)
  );

  // Datapath operations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_sum_r <= '0;
      prior_meas_r   <= '0;
      primed_r       <= 1'b0;
      use_rate_r     <= 1'b0;
    end else if (step_fire) begin
      case (ucw.alu)
        pidc_pkg::A_LOAD: begin
          meas_r <= in_measurement;
          dt_r   <= in_elapsed;
        end
        pidc_pkg::A_ERR: begin
          e_r    <= (W+1)'(target_r) - (W+1)'(meas_r);
          diff_r <= (W+1)'(meas_r) - (W+1)'(prior_meas_r);
        end
        pidc_pkg::A_CHECK: begin
          err_r      <= err_sat;
          use_rate_r <= primed_r && (dt_r != '0);
        end
        pidc_pkg::A_INT_SUM: begin
          acc_r <= (W+2)'(integral_sum_r) + (W+2)'(mul_res);
        end
        pidc_pkg::A_INT_CLAMP: begin
          integ_r <= clamp(sat_acc(acc_r), drive_floor_r, drive_ceiling_r);
        end
        pidc_pkg::A_P_SUM: begin
          acc_r <= (W+2)'(integ_r) + (W+2)'(mul_res);
        end
        pidc_pkg::A_D_SUB: begin
          acc_r <= acc_r - (W+2)'(mul_res);
        end
        pidc_pkg::A_DRIVE: begin
          // commit the loop state with the result
          integral_sum_r <= integ_r;
          prior_meas_r   <= meas_r;
          primed_r       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register: load at the last step, drop after the transfer
  assign out_load = step_fire &&
                    ((ucw.alu == pidc_pkg::A_DRIVE) || (ucw.alu == pidc_pkg::A_SETTLE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      if (ucw.alu == pidc_pkg::A_SETTLE) begin
        out_drive_r   <= '0;
        out_settled_r <= 1'b1;
      end else begin
        out_drive_r   <= clamp(sat_acc(acc_r), drive_floor_r, drive_ceiling_r);
        out_settled_r <= 1'b0;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_settled = out_settled_r;

  // Checks
  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_go |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |-> !div_busy)
    else $error("divider started while busy");

  a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      ($past(step_r) == pidc_pkg::ST_DRIVE || $past(step_r) == pidc_pkg::ST_SETTLE))
    else $error("result loaded outside an output step");

  a_drive_commits_state: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && !out_settled_r) |-> primed_r)
    else $error("drive delivered without committing loop state");

endmodule
